// ===== src/utf8_byte_stream_decoder_assert.svh =====
// Assertion macros shared by the checker of the UTF-8 byte stream decoder.
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define UBSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define UBSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ubsd_pkg.sv =====
// Types, codes and helper functions shared by the UTF-8 byte stream decoder.
package ubsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } byte_word_t;

    typedef struct packed {
        logic [31:0] code_point;
        status_t     status;
        logic [2:0]  byte_count;
        logic        last_of_run;
    } char_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
        logic [2:0] lead_len;
        logic       is_cont;
    } entry_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if ((b & 8'he0) == 8'hc0) begin
            len = 3'd2;
        end else if ((b & 8'hf0) == 8'he0) begin
            len = 3'd3;
        end else if ((b & 8'hf8) == 8'hf0) begin
            len = 3'd4;
        end else if ((b & 8'hfc) == 8'hf8) begin
            len = 3'd5;
        end else if ((b & 8'hfc) == 8'hfc) begin
            len = 3'd6;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [2:0] len);
        logic [7:0] mask;
        case (len)
            3'd1:    mask = 8'h7f;
            3'd2:    mask = 8'h1f;
            3'd3:    mask = 8'h0f;
            3'd4:    mask = 8'h07;
            default: mask = 8'h03;
        endcase
        return mask;
    endfunction

endpackage

// ===== src/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder for the 1 to 6 byte legacy form.
// An accepted byte is written into the queue, then decoded at the queue head, and its
// result is registered in the output register.
// Throughput: one byte per cycle while no stalled result is held, set by the single decode step in the back part.
// A byte that closes a bad sequence and also yields its own result stays queued for its own result.
// Reset empties the queue, leaves the decoder idle and drops any pending result.
module utf8_byte_stream_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  ubsd_pkg::byte_word_t byte_word,
    output logic                 char_valid,
    input  logic                 char_stall,
    output ubsd_pkg::char_word_t char_word
);
    import ubsd_pkg::*;

    logic   queue_full;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    ubsd_front u_front (
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ubsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ubsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

endmodule

// ===== src/ubsd_front.sv =====
// Input side: accepts bytes, classifies them and writes them into the queue.
module ubsd_front (
    input  logic                byte_valid,
    output logic                byte_stall,
    input  ubsd_pkg::byte_word_t byte_word,
    input  logic                queue_full,
    output logic                push,
    output ubsd_pkg::entry_t    push_entry
);
    import ubsd_pkg::*;

    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;

    always_comb
    begin
        push_entry.data_byte     = byte_word.data_byte;
        push_entry.end_of_buffer = byte_word.end_of_buffer;
        push_entry.lead_len      = lead_length(byte_word.data_byte);
        push_entry.is_cont       = (byte_word.data_byte[7:6] == 2'b10);
    end

endmodule

// ===== src/ubsd_queue.sv =====
// Short queue of classified bytes between the front and the decoder.
module ubsd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ubsd_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output ubsd_pkg::entry_t head_entry
);
    import ubsd_pkg::*;

    entry_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (!push && pop) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/ubsd_back.sv =====
// Decoder: gathers sequences from classified bytes and drives the result register.
module ubsd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  ubsd_pkg::entry_t     head_entry,
    output logic                 pop,
    output logic                 char_valid,
    input  logic                 char_stall,
    output ubsd_pkg::char_word_t char_word
);
    import ubsd_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [2:0]  rem_reg;
    logic [2:0]  rem_next;
    logic [2:0]  seq_reg;
    logic [2:0]  seq_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    char_word_t  out_word_reg;
    char_word_t  out_word_next;

    logic        advance;
    logic        emit;
    logic        lead_emits;
    logic [31:0] acc_shift;
    logic [2:0]  rem_dec;
    logic [31:0] lead_acc;

    assign char_valid = out_valid_reg;
    assign char_word  = out_word_reg;

    always_comb
    begin
        advance    = head_valid && (!out_valid_reg || !char_stall);
        lead_emits = (head_entry.lead_len < 3'd2) || head_entry.end_of_buffer;
        acc_shift  = {acc_reg[25:0], head_entry.data_byte[5:0]};
        rem_dec    = rem_reg - 3'd1;
        lead_acc   = {24'd0, head_entry.data_byte & lead_mask(head_entry.lead_len)};

        acc_next      = acc_reg;
        rem_next      = rem_reg;
        seq_next      = seq_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        out_word_next = out_word_reg;

        if (advance) begin
            out_word_next.last_of_run = 1'b1;
            if (rem_reg == 3'd0) begin
                pop = 1'b1;
                if (head_entry.lead_len == 3'd0) begin
                    emit                     = 1'b1;
                    out_word_next.code_point = '0;
                    out_word_next.status     = ST_BAD_LEAD;
                    out_word_next.byte_count = 3'd1;
                end else if (head_entry.lead_len == 3'd1) begin
                    emit                     = 1'b1;
                    out_word_next.code_point = {24'd0, head_entry.data_byte};
                    out_word_next.status     = ST_OK;
                    out_word_next.byte_count = 3'd1;
                end else begin
                    acc_next = lead_acc;
                    seq_next = head_entry.lead_len;
                    rem_next = head_entry.lead_len - 3'd1;
                    if (head_entry.end_of_buffer) begin
                        emit                     = 1'b1;
                        out_word_next.code_point = lead_acc;
                        out_word_next.status     = ST_TRUNC;
                        out_word_next.byte_count = head_entry.lead_len;
                        rem_next                 = 3'd0;
                    end
                end
            end else if (!head_entry.is_cont) begin
                // The byte is kept in the queue when its own lead result must follow.
                emit                      = 1'b1;
                out_word_next.code_point  = '0;
                out_word_next.status      = ST_BAD_CONT;
                out_word_next.byte_count  = seq_reg;
                out_word_next.last_of_run = !lead_emits;
                rem_next                  = 3'd0;
                if (!lead_emits) begin
                    pop      = 1'b1;
                    acc_next = lead_acc;
                    seq_next = head_entry.lead_len;
                    rem_next = head_entry.lead_len - 3'd1;
                end
            end else begin
                pop      = 1'b1;
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 3'd0) begin
                    emit                     = 1'b1;
                    out_word_next.code_point = acc_shift;
                    out_word_next.status     = ST_OK;
                    out_word_next.byte_count = seq_reg;
                end else if (head_entry.end_of_buffer) begin
                    emit                     = 1'b1;
                    out_word_next.code_point = acc_shift;
                    out_word_next.status     = ST_TRUNC;
                    out_word_next.byte_count = seq_reg;
                    rem_next                 = 3'd0;
                end
            end
        end

        if (advance) begin
            out_valid_next = emit;
        end else if (!char_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg       <= '0;
            rem_reg       <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

// ===== src/ubsd_checker.sv =====
// Port checker for the UTF-8 byte stream decoder and its bind statement.
`include "utf8_byte_stream_decoder_assert.svh"

module ubsd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 char_valid,
    input logic                 char_stall,
    input ubsd_pkg::char_word_t char_word
);
    import ubsd_pkg::*;

    logic held;
    logic bad_result;
    logic lead_fault;
    logic count_ok;
    logic trunc_result;

    assign held         = char_valid && char_stall;
    assign bad_result   = char_valid && (char_word.status == ST_BAD_LEAD ||
                                         char_word.status == ST_BAD_CONT);
    assign lead_fault   = char_valid && char_word.status == ST_BAD_LEAD;
    assign count_ok     = char_word.byte_count != 3'd0 && char_word.byte_count != 3'd7;
    assign trunc_result = char_valid && char_word.status == ST_TRUNC;

    `UBSD_ASSERT_NEXT(a_out_hold, held, char_valid && $stable(char_word), "stalled word changed")
    `UBSD_ASSERT_NOW(a_bad_zero, bad_result, char_word.code_point == 32'd0, "nonzero error code")
    `UBSD_ASSERT_NOW(a_bad_lead_one, lead_fault, char_word.byte_count == 3'd1, "bad lead count")
    `UBSD_ASSERT_NOW(a_count_range, char_valid, count_ok, "byte count out of range")
    `UBSD_ASSERT_NOW(a_trunc_last, trunc_result, char_word.last_of_run, "truncated word not last")

endmodule

bind utf8_byte_stream_decoder ubsd_checker u_ubsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the UTF-8 byte stream decoder.
`timescale 1ns / 100ps

module testbench;

    import ubsd_pkg::*;

    localparam int RANDOM_BYTES = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0]  data_byte;
        logic        eob;
        logic        typed;
        logic [31:0] code;
        status_t     st;
        logic [2:0]  count;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_word_t byte_word;
    logic       char_valid;
    logic       char_stall;
    char_word_t char_word;

    logic [31:0] acc;
    logic [2:0]  remaining;
    logic [2:0]  seq_len;
    char_word_t  step_chars[$];
    char_word_t  pending_chars[$];
    char_word_t  due;

    bit gaps_on = 1'b1;
    bit hold_done = 1'b0;
    int bytes_sent = 0;
    int chars_seen = 0;
    int errors = 0;
    int cycles = 0;
    int seen_status [4] = '{0, 0, 0, 0};

    // Rows with a typed result give exactly one word; the rest rely on the predictor.
    row_t plan [0:24] = '{
        '{8'h00, 1'b0, 1'b1, 32'h0000_0000, ST_OK,       3'd1},
        '{8'h7f, 1'b1, 1'b1, 32'h0000_007f, ST_OK,       3'd1},
        '{8'h80, 1'b0, 1'b1, 32'h0000_0000, ST_BAD_LEAD, 3'd1},
        '{8'hbf, 1'b1, 1'b1, 32'h0000_0000, ST_BAD_LEAD, 3'd1},
        '{8'hc2, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'ha9, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'he2, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'h41, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hf0, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'h9f, 1'b1, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hff, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hbf, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hbf, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hbf, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hbf, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hbf, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hf8, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'h80, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'h80, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'h80, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'h80, 1'b1, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'he0, 1'b1, 1'b1, 32'h0000_0000, ST_TRUNC,    3'd3},
        '{8'hc0, 1'b0, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hf4, 1'b1, 1'b0, 32'h0,         ST_OK,       3'd0},
        '{8'hfe, 1'b1, 1'b1, 32'h0000_0002, ST_TRUNC,    3'd6}
    };

    utf8_byte_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [2:0] length_of_lead(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b0???????: len = 3'd1;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            8'b111110??: len = 3'd5;
            8'b111111??: len = 3'd6;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] make_lead(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       r[7]   = 1'b0;
            2:       r[7:5] = 3'b110;
            3:       r[7:4] = 4'b1110;
            4:       r[7:3] = 5'b11110;
            5:       r[7:2] = 6'b111110;
            default: r[7:2] = 6'b111111;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] make_cont();
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic char_word_t char_of(input logic [31:0] code, input status_t st,
                                           input logic [2:0] count);
        return '{code_point: code, status: st, byte_count: count, last_of_run: 1'b0};
    endfunction

    task automatic open_lead(input logic [7:0] b, input logic eob);
        logic [2:0] len;
        len = length_of_lead(b);
        if (len == 3'd0)
        begin
            step_chars.push_back(char_of(32'h0, ST_BAD_LEAD, 3'd1));
        end
        else if (len == 3'd1)
        begin
            step_chars.push_back(char_of({24'h0, b}, ST_OK, 3'd1));
        end
        else
        begin
            case (len)
                3'd2:    acc = {27'h0, b[4:0]};
                3'd3:    acc = {28'h0, b[3:0]};
                3'd4:    acc = {29'h0, b[2:0]};
                default: acc = {30'h0, b[1:0]};
            endcase
            seq_len   = len;
            remaining = len - 3'd1;
            if (eob)
            begin
                step_chars.push_back(char_of(acc, ST_TRUNC, len));
                remaining = 3'd0;
            end
        end
    endtask

    task automatic decode_step(input logic [7:0] b, input logic eob);
        step_chars.delete();
        if (remaining != 3'd0 && b[7:6] == 2'b10)
        begin
            acc       = {acc[25:0], b[5:0]};
            remaining = remaining - 3'd1;
            if (remaining == 3'd0)
            begin
                step_chars.push_back(char_of(acc, ST_OK, seq_len));
            end
            else if (eob)
            begin
                step_chars.push_back(char_of(acc, ST_TRUNC, seq_len));
                remaining = 3'd0;
            end
        end
        else
        begin
            if (remaining != 3'd0)
            begin
                step_chars.push_back(char_of(32'h0, ST_BAD_CONT, seq_len));
                remaining = 3'd0;
            end
            open_lead(b, eob);
        end
        if (step_chars.size() > 0)
        begin
            step_chars[step_chars.size() - 1].last_of_run = 1'b1;
        end
    endtask

    task automatic send_byte(input row_t r);
        while (gaps_on && $urandom_range(99) < 16)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word  <= '{data_byte: r.data_byte, end_of_buffer: r.eob};
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        decode_step(r.data_byte, r.eob);
        if (r.typed)
        begin
            pending_chars.push_back('{code_point: r.code, status: r.st,
                                      byte_count: r.count, last_of_run: 1'b1});
        end
        else
        begin
            foreach (step_chars[i])
            begin
                pending_chars.push_back(step_chars[i]);
            end
        end
        bytes_sent++;
    endtask

    task automatic flag_field(input string fld, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, fld, want, got);
        end
    endtask

    initial
    begin : char_stall_drive
        int hold;
        hold       = 0;
        char_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                char_stall <= 1'b1;
            end
            else if (!hold_done && bytes_sent >= 200)
            begin
                hold_done = 1'b1;
                hold      = 80;
                char_stall <= 1'b1;
            end
            else
            begin
                char_stall <= gaps_on && ($urandom_range(99) < 16);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %h with nothing pending", $time, char_word);
            end
            else
            begin
                due = pending_chars.pop_front();
                flag_field("code_point", due.code_point, char_word.code_point);
                flag_field("status", 32'(due.status), 32'(char_word.status));
                flag_field("byte_count", 32'(due.byte_count), 32'(char_word.byte_count));
                flag_field("last_of_run", 32'(due.last_of_run), 32'(char_word.last_of_run));
                chars_seen++;
                seen_status[due.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t r;
        int   pick;
        int   len;
        int   cut;
        int   k;
        int   random_sent;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_word  = '0;
        acc        = 32'h0;
        remaining  = 3'd0;
        seq_len    = 3'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 25; k++)
        begin
            send_byte(plan[k]);
        end

        r.typed     = 1'b0;
        r.code      = 32'h0;
        r.st        = ST_OK;
        r.count     = 3'd0;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            gaps_on = !(random_sent >= 300 && random_sent < 450);
            pick    = $urandom_range(99);
            if (pick < 85)
            begin
                // Well-formed sequences, or ones broken off by a non-continuation word.
                len = $urandom_range(1, 6);
                cut = len;
                if (pick >= 70 && len > 1)
                begin
                    cut = $urandom_range(1, len - 1);
                end
                r.data_byte = make_lead(len);
                r.eob       = ($urandom_range(19) == 0);
                send_byte(r);
                random_sent++;
                for (k = 1; k < cut; k++)
                begin
                    r.data_byte = make_cont();
                    r.eob       = ($urandom_range(19) == 0);
                    send_byte(r);
                    random_sent++;
                end
                if (cut < len)
                begin
                    r.data_byte = 8'($urandom);
                    if (r.data_byte[7:6] == 2'b10)
                    begin
                        r.data_byte[6] = 1'b1;
                    end
                    r.eob = ($urandom_range(9) == 0);
                    send_byte(r);
                    random_sent++;
                end
            end
            else
            begin
                r.data_byte = 8'($urandom);
                r.eob       = 1'($urandom);
                send_byte(r);
                random_sent++;
            end
        end
        gaps_on = 1'b1;
        byte_valid <= 1'b0;

        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d bytes sent, %0d characters checked, one long output hold-off",
                 bytes_sent, chars_seen);
        $display("tb: ok %0d, bad lead %0d, bad continuation %0d, truncated %0d",
                 seen_status[ST_OK], seen_status[ST_BAD_LEAD],
                 seen_status[ST_BAD_CONT], seen_status[ST_TRUNC]);
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
